>>> sv/efr_pkg.sv
package efr_pkg;

   // Depth of both queues; a power of two so the pointers wrap on their own.
   localparam int QueueDepth = 2;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   localparam logic [1:0] CSR_START_MARKER  = 2'd0;
   localparam logic [1:0] CSR_ESCAPE_MARKER = 2'd1;
   localparam logic [1:0] CSR_CHECKSUM_SEED = 2'd2;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_ACK  = 1'b1;

   typedef enum logic [7:0] {
      PHASE_WAIT = 8'b0000_0001,
      PHASE_FROM = 8'b0000_0010,
      PHASE_TO   = 8'b0000_0100,
      PHASE_CMD  = 8'b0000_1000,
      PHASE_LEN  = 8'b0001_0000,
      PHASE_HSUM = 8'b0010_0000,
      PHASE_DATA = 8'b0100_0000,
      PHASE_DSUM = 8'b1000_0000
   } phase_type;

   typedef enum logic [2:0] {
      STATUS_NONE      = 3'd0,
      STATUS_PAYLOAD   = 3'd1,
      STATUS_OK        = 3'd2,
      STATUS_HDR_ERR   = 3'd3,
      STATUS_DATA_ERR  = 3'd4,
      STATUS_REJECTED  = 3'd5,
      STATUS_ACKED     = 3'd6
   } status_type;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
      logic       is_start;
      logic       is_escape;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [7:0]  source_addr;
      logic [7:0]  dest_addr;
      logic [7:0]  command;
      logic [7:0]  payload_length;
      logic        packet_pending;
      logic [31:0] received_count;
      logic [31:0] rejected_count;
      logic [31:0] header_error_count;
   } result_type;

endpackage

>>> sv/efr_front.sv
module efr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic              req_op,
   input  logic [7:0]        req_rx_byte,
   input  logic [7:0]        start_marker,
   input  logic [7:0]        escape_marker,
   output logic              item_valid,
   output efr_pkg::item_type item,
   input  logic              item_pop
);

   efr_pkg::item_type                   queue_ff [efr_pkg::QueueDepth];
   logic [efr_pkg::PtrWidth-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [efr_pkg::PtrWidth-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [efr_pkg::CountWidth-1:0]      count_ff, count_in;
   efr_pkg::item_type                   classified;
   logic                                do_push;
   logic                                do_pop;

   // Marker matches are decided here on the raw byte; the back end only
   // has to look at the flags.
   always_comb begin
      classified.op        = req_op;
      classified.rx_byte   = req_rx_byte;
      classified.is_start  = (req_rx_byte == start_marker);
      classified.is_escape = (req_rx_byte == escape_marker);
   end

   assign full       = (count_ff == efr_pkg::CountWidth'(efr_pkg::QueueDepth));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/efr_back.sv
module efr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  efr_pkg::item_type   item,
   output logic                item_pop,
   input  logic [7:0]          escape_marker,
   input  logic [7:0]          checksum_seed,
   output logic                empty,
   input  logic                pop,
   output efr_pkg::result_type result
);

   efr_pkg::phase_type  phase_ff, phase_in;
   efr_pkg::phase_type  phase_cur;
   logic                escape_ff, escape_in;
   logic [7:0]          remaining_ff, remaining_in;
   logic [7:0]          position_ff, position_in;
   logic [7:0]          xor_ff, xor_in;
   logic [7:0]          from_ff, from_in;
   logic [7:0]          to_ff, to_in;
   logic [7:0]          cmd_ff, cmd_in;
   logic [7:0]          length_ff, length_in;
   logic                pending_ff, pending_in;
   logic [31:0]         accepted_ff, accepted_in;
   logic [31:0]         dropped_ff, dropped_in;
   logic [31:0]         hdr_fail_ff, hdr_fail_in;
   logic [7:0]          value;
   logic [7:0]          remaining_dec;
   logic                proceed;
   efr_pkg::status_type status;
   logic [7:0]          out_byte;
   logic [7:0]          out_index;
   efr_pkg::result_type step_result;
   logic                fire;

   efr_pkg::result_type                 queue_ff [efr_pkg::QueueDepth];
   logic [efr_pkg::PtrWidth-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [efr_pkg::CountWidth-1:0]      count_ff, count_in;
   logic                                do_pop;

   assign fire          = item_valid &&
                          (count_ff != efr_pkg::CountWidth'(efr_pkg::QueueDepth));
   assign item_pop      = fire;
   assign remaining_dec = remaining_ff - 8'd1;

   always_comb begin
      phase_in    = phase_ff;
      phase_cur   = phase_ff;
      escape_in   = escape_ff;
      remaining_in = remaining_ff;
      position_in = position_ff;
      xor_in      = xor_ff;
      from_in     = from_ff;
      to_in       = to_ff;
      cmd_in      = cmd_ff;
      length_in   = length_ff;
      pending_in  = pending_ff;
      accepted_in = accepted_ff;
      dropped_in  = dropped_ff;
      hdr_fail_in = hdr_fail_ff;
      status      = efr_pkg::STATUS_NONE;
      out_byte    = 8'd0;
      out_index   = 8'd0;
      value       = item.rx_byte;
      proceed     = 1'b0;

      if (fire) begin
         if (item.op == efr_pkg::OP_ACK) begin
            pending_in = 1'b0;
            status     = efr_pkg::STATUS_ACKED;
         end else if (pending_ff) begin
            if (!(&dropped_ff)) begin
               dropped_in = dropped_ff + 32'd1;
            end
            status = efr_pkg::STATUS_REJECTED;
         end else begin
            if (!(&accepted_ff)) begin
               accepted_in = accepted_ff + 32'd1;
            end
            proceed = 1'b1;
            if (!escape_ff) begin
               if (item.is_start) begin
                  phase_cur = efr_pkg::PHASE_WAIT;
               end else if (item.is_escape) begin
                  escape_in = 1'b1;
                  proceed   = 1'b0;
               end
            end else begin
               value     = item.rx_byte + escape_marker;
               escape_in = 1'b0;
            end
         end
      end

      if (proceed) begin
         phase_in = phase_cur;
         unique case (phase_cur)
            efr_pkg::PHASE_WAIT: begin
               // A start marker opens a frame here even right after an escape.
               if (item.is_start) begin
                  remaining_in = 8'd0;
                  position_in  = 8'd0;
                  xor_in       = checksum_seed;
                  phase_in     = efr_pkg::PHASE_FROM;
               end
            end
            efr_pkg::PHASE_FROM: begin
               xor_in   = xor_ff ^ value;
               from_in  = value;
               phase_in = efr_pkg::PHASE_TO;
            end
            efr_pkg::PHASE_TO: begin
               xor_in   = xor_ff ^ value;
               to_in    = value;
               phase_in = efr_pkg::PHASE_CMD;
            end
            efr_pkg::PHASE_CMD: begin
               xor_in   = xor_ff ^ value;
               cmd_in   = value;
               phase_in = efr_pkg::PHASE_LEN;
            end
            efr_pkg::PHASE_LEN: begin
               xor_in       = xor_ff ^ value;
               length_in    = value;
               remaining_in = value;
               phase_in     = efr_pkg::PHASE_HSUM;
            end
            efr_pkg::PHASE_HSUM: begin
               if (value != xor_ff) begin
                  if (!(&hdr_fail_ff)) begin
                     hdr_fail_in = hdr_fail_ff + 32'd1;
                  end
                  status   = efr_pkg::STATUS_HDR_ERR;
                  phase_in = efr_pkg::PHASE_WAIT;
               end else begin
                  xor_in = checksum_seed;
                  if (remaining_ff != 8'd0) begin
                     phase_in = efr_pkg::PHASE_DATA;
                  end else begin
                     pending_in = 1'b1;
                     status     = efr_pkg::STATUS_OK;
                     phase_in   = efr_pkg::PHASE_WAIT;
                  end
               end
            end
            efr_pkg::PHASE_DATA: begin
               xor_in       = xor_ff ^ value;
               status       = efr_pkg::STATUS_PAYLOAD;
               out_byte     = value;
               out_index    = position_ff;
               position_in  = position_ff + 8'd1;
               remaining_in = remaining_dec;
               if (remaining_dec == 8'd0) begin
                  phase_in = efr_pkg::PHASE_DSUM;
               end
            end
            efr_pkg::PHASE_DSUM: begin
               // Position counts the payload beats of this frame, so a zero
               // position here means no payload was checked.
               if ((position_ff == 8'd0) || (value == xor_ff)) begin
                  pending_in = 1'b1;
                  status     = efr_pkg::STATUS_OK;
               end else begin
                  pending_in = 1'b0;
                  status     = efr_pkg::STATUS_DATA_ERR;
               end
               phase_in = efr_pkg::PHASE_WAIT;
            end
            default: begin
               phase_in = efr_pkg::PHASE_WAIT;
            end
         endcase
      end
   end

   always_comb begin
      step_result.status             = status;
      step_result.payload_byte       = out_byte;
      step_result.payload_index      = out_index;
      step_result.source_addr        = from_in;
      step_result.dest_addr          = to_in;
      step_result.command            = cmd_in;
      step_result.payload_length     = length_in;
      step_result.packet_pending     = pending_in;
      step_result.received_count     = accepted_in;
      step_result.rejected_count     = dropped_in;
      step_result.header_error_count = hdr_fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= efr_pkg::PHASE_WAIT;
         escape_ff    <= 1'b0;
         remaining_ff <= 8'd0;
         position_ff  <= 8'd0;
         xor_ff       <= 8'd0;
         from_ff      <= 8'd0;
         to_ff        <= 8'd0;
         cmd_ff       <= 8'd0;
         length_ff    <= 8'd0;
         pending_ff   <= 1'b0;
         accepted_ff  <= 32'd0;
         dropped_ff   <= 32'd0;
         hdr_fail_ff  <= 32'd0;
      end else begin
         phase_ff     <= phase_in;
         escape_ff    <= escape_in;
         remaining_ff <= remaining_in;
         position_ff  <= position_in;
         xor_ff       <= xor_in;
         from_ff      <= from_in;
         to_ff        <= to_in;
         cmd_ff       <= cmd_in;
         length_ff    <= length_in;
         pending_ff   <= pending_in;
         accepted_ff  <= accepted_in;
         dropped_ff   <= dropped_in;
         hdr_fail_ff  <= hdr_fail_in;
      end
   end

   // Result queue: the oldest beat sits on the ports while it is not empty.
   assign empty  = (count_ff == '0);
   assign result = queue_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (fire && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         queue_ff[wr_ptr_ff] <= step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (fire) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

>>> sv/escaped_xor_frame_receiver.sv
// Byte-stuffed frame receiver with header and data XOR checks.
// Input side is a queue: drive req_op and req_rx_byte with push; a beat is
// taken at a clock edge where push is high and full is low. req_op high
// acknowledges a pending packet, low delivers one raw line byte.
// Result side is a queue as well: while empty is low, the oldest result
// beat is on the rsp_ ports and pop takes it. Every input beat yields
// exactly one result beat, in order.
// The csr_ port writes start marker, escape marker and checksum seed
// (indexes 0, 1, 2); write only while no beats are in flight.
// A result beat passes through the input queue and then the result queue
// before it shows on the rsp_ ports. One beat per cycle is sustained while
// the result queue has room: the parser computes its next state
// combinationally, and two-entry queues on each side of it absorb stalls.
// When pop is held low the result queue fills, the parser stops, and the
// input queue raises full after two more beats.
// Synchronous reset empties both queues, returns the parser to waiting for
// a start marker, clears all counters and restores the register defaults.
module escaped_xor_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_op,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [7:0]  rsp_source_addr,
   output logic [7:0]  rsp_dest_addr,
   output logic [7:0]  rsp_command,
   output logic [7:0]  rsp_payload_length,
   output logic        rsp_packet_pending,
   output logic [31:0] rsp_received_count,
   output logic [31:0] rsp_rejected_count,
   output logic [31:0] rsp_header_error_count,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]          start_marker_ff;
   logic [7:0]          escape_marker_ff;
   logic [7:0]          checksum_seed_ff;
   logic                item_valid;
   logic                item_pop;
   efr_pkg::item_type   item;
   efr_pkg::result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff  <= 8'd241;
         escape_marker_ff <= 8'd240;
         checksum_seed_ff <= 8'd0;
      end else if (csr_we) begin
         if (csr_index == efr_pkg::CSR_START_MARKER) begin
            start_marker_ff <= csr_wdata;
         end
         if (csr_index == efr_pkg::CSR_ESCAPE_MARKER) begin
            escape_marker_ff <= csr_wdata;
         end
         if (csr_index == efr_pkg::CSR_CHECKSUM_SEED) begin
            checksum_seed_ff <= csr_wdata;
         end
      end
   end

   efr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_op        (req_op),
      .req_rx_byte   (req_rx_byte),
      .start_marker  (start_marker_ff),
      .escape_marker (escape_marker_ff),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   efr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop),
      .escape_marker (escape_marker_ff),
      .checksum_seed (checksum_seed_ff),
      .empty         (empty),
      .pop           (pop),
      .result        (result)
   );

   assign rsp_status             = result.status;
   assign rsp_payload_byte       = result.payload_byte;
   assign rsp_payload_index      = result.payload_index;
   assign rsp_source_addr        = result.source_addr;
   assign rsp_dest_addr          = result.dest_addr;
   assign rsp_command            = result.command;
   assign rsp_payload_length     = result.payload_length;
   assign rsp_packet_pending     = result.packet_pending;
   assign rsp_received_count     = result.received_count;
   assign rsp_rejected_count     = result.rejected_count;
   assign rsp_header_error_count = result.header_error_count;

endmodule
